// File: design/kti_pkg.sv
package kti_pkg;

   localparam int MaxKeys = 16;
   localparam int IdxW    = $clog2(MaxKeys);
   localparam int CntW    = $clog2(MaxKeys + 1);
   localparam int DivW    = 32;
   localparam int AlphaW  = 16;
   localparam int StepW   = $clog2(DivW);

   localparam logic [31:0] DupStep = 32'd6554;

   // opcodes
   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_QUERY   = 3'd1;
   localparam logic [2:0] OP_DELETE  = 3'd2;
   localparam logic [2:0] OP_MOVE_DN = 3'd3;
   localparam logic [2:0] OP_MOVE_UP = 3'd4;
   localparam logic [2:0] OP_DUP     = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   // blend lanes
   localparam logic [3:0] LANE_POS_X  = 4'd0;
   localparam logic [3:0] LANE_POS_Y  = 4'd1;
   localparam logic [3:0] LANE_SIZE_X = 4'd2;
   localparam logic [3:0] LANE_SIZE_Y = 4'd3;
   localparam logic [3:0] LANE_ANGLE  = 4'd4;
   localparam logic [3:0] LANE_RED    = 4'd5;
   localparam logic [3:0] LANE_GREEN  = 4'd6;
   localparam logic [3:0] LANE_BLUE   = 4'd7;
   localparam logic [3:0] LANE_ALPHA  = 4'd8;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [31:0]        time_req;
      logic [3:0]         index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] size_x;
      logic signed [31:0] size_y;
      logic signed [31:0] angle;
      logic [31:0]        color_in;
      logic [15:0]        list_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_size_x;
      logic signed [31:0] out_size_y;
      logic signed [31:0] out_angle;
      logic [31:0]        out_color;
      logic [15:0]        out_list;
      logic [1:0]         status;
      logic [4:0]         key_count_out;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        key_time;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] size_x;
      logic signed [31:0] size_y;
      logic signed [31:0] angle;
      logic [31:0]        color;
      logic [15:0]        list;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_LOOP_RD, S_LOOP_CHK, S_DIV, S_MOD_DONE,
      S_SRCH_RD, S_SRCH_CMP, S_SHUP_RD, S_SHUP_WR, S_FIN_WR,
      S_DEL_RD, S_DEL_WR, S_SW_RDA, S_SW_RDB, S_SW_WRA, S_SW_WRB,
      S_DUP_RDA, S_DUP_RDB, S_DUP_T, S_Q_RDA, S_Q_RDB, S_Q_DIV,
      S_EMIT_RD, S_EMIT, S_MIX_MUL, S_MIX_ACC, S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      WR_COPY, WR_NEW, WR_SWAP_A, WR_SWAP_B, WR_DUP
   } wr_sel_type;

   typedef enum logic [1:0] {
      C_REQ, C_ZERO, C_REM
   } c_sel_type;

   typedef struct packed {
      logic             req_load;
      logic             rd_en;
      logic [IdxW-1:0]  rd_addr;
      logic             wr_en;
      logic [IdxW-1:0]  wr_addr;
      wr_sel_type       wr_sel;
      logic             hold_load;
      logic             c_load;
      c_sel_type        c_sel;
      logic             div_mod_start;
      logic             div_alpha_start;
      logic             div_step;
      logic             nt_load;
      logic             dup_last;
      logic             frame_clr;
      logic             emit;
      logic             mul;
      logic             acc;
      logic [3:0]       lane;
      logic             rsp_load;
      logic [1:0]       status;
      logic [CntW-1:0]  count;
   } cmd_type;

   typedef struct packed {
      logic [2:0]      opcode;
      logic [IdxW-1:0] index;
      logic            time_gt;
      logic            dur_zero;
      logic            rsp_busy;
   } sts_type;

endpackage

// File: design/keyframe_table_interpolator_top.sv
// Keyframe table interpolator: a time-sorted table of up to 16 keyframes.
// Requests arrive on req_valid/req_ready carrying one operation (insert,
// query, delete, move down, move up, duplicate); each request produces
// exactly one response on rsp_valid/rsp_ready with status and key count,
// plus the frame for a query, blended between two keys or taken from an end key.
// csr_we/csr_wdata writes loop mode; write it only while the block is idle.
// One request is worked on at a time through a key table with one read port and
// one write port, read one entry per cycle. Insert searches for its place, shifts
// later entries up and writes the new key; duplicate shifts and writes a copy with
// a new time; delete shifts the entries after the index down; move swaps two
// neighbours but keeps their times. Query searches for the span, divides for the
// blend factor and blends each lane in turn, or takes an end key as it stands;
// with loop mode it first takes the query time modulo the last key time.
// One restoring divider is shared by the modulo and the blend factor.
// Reset empties the table and clears loop mode. A stalled response holds in
// the output register; a new request is taken as soon as the block is idle,
// but its response waits until the earlier one is taken.
module keyframe_table_interpolator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kti_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata
);
   import kti_pkg::*;

   cmd_type cmd;
   sts_type sts;

   kti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .sts       (sts),
      .cmd       (cmd)
   );

   kti_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: design/kti_ctrl.sv
module kti_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             csr_we,
   input  logic             csr_wdata,
   input  kti_pkg::sts_type sts,
   output kti_pkg::cmd_type cmd
);
   import kti_pkg::*;

   state_type       state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] j_ff, j_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [3:0]      lane_ff, lane_in;
   logic [1:0]      st_ff, st_in;
   logic            alpha_ff, alpha_in;
   logic            loop_ff;

   logic [CntW-1:0] idx5, jm1, jp1, posp1, cntm1;
   logic            srch_done;

   assign idx5  = {1'b0, sts.index};
   assign jm1   = j_ff - 1'b1;
   assign jp1   = j_ff + 1'b1;
   assign posp1 = pos_ff + 1'b1;
   assign cntm1 = cnt_ff - 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   // loop mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff <= 1'b0;
      end else if (csr_we) begin
         loop_ff <= csr_wdata;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         j_ff     <= '0;
         pos_ff   <= '0;
         step_ff  <= '0;
         lane_ff  <= '0;
         st_ff    <= ST_OK;
         alpha_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         j_ff     <= j_in;
         pos_ff   <= pos_in;
         step_ff  <= step_in;
         lane_ff  <= lane_in;
         st_ff    <= st_in;
         alpha_ff <= alpha_in;
      end
   end

   // next state and counters
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      j_in      = j_ff;
      pos_in    = pos_ff;
      step_in   = step_ff;
      lane_in   = lane_ff;
      st_in     = st_ff;
      alpha_in  = alpha_ff;
      srch_done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            st_in = ST_OK;
            case (sts.opcode)
               OP_INSERT: begin
                  if (cnt_ff == CntW'(MaxKeys)) begin
                     st_in = ST_FULL;
                     state_in = S_FINISH;
                  end else begin
                     j_in = '0;
                     state_in = S_SRCH_RD;
                  end
               end
               OP_QUERY: begin
                  if (cnt_ff == '0) begin
                     st_in = ST_EMPTY;
                     state_in = S_FINISH;
                  end else if (loop_ff) begin
                     state_in = S_LOOP_RD;
                  end else begin
                     j_in = '0;
                     state_in = S_SRCH_RD;
                  end
               end
               OP_DELETE: begin
                  if (idx5 >= cnt_ff) begin
                     st_in = ST_IGNORED;
                     state_in = S_FINISH;
                  end else begin
                     j_in = idx5;
                     state_in = S_DEL_RD;
                  end
               end
               OP_MOVE_DN: begin
                  if (idx5 == '0 || idx5 >= cnt_ff) begin
                     st_in = ST_IGNORED;
                     state_in = S_FINISH;
                  end else begin
                     pos_in = idx5 - 1'b1;
                     state_in = S_SW_RDA;
                  end
               end
               OP_MOVE_UP: begin
                  if (idx5 + 1'b1 >= cnt_ff) begin
                     st_in = ST_IGNORED;
                     state_in = S_FINISH;
                  end else begin
                     pos_in = idx5;
                     state_in = S_SW_RDA;
                  end
               end
               OP_DUP: begin
                  if (idx5 >= cnt_ff) begin
                     st_in = ST_IGNORED;
                     state_in = S_FINISH;
                  end else if (cnt_ff == CntW'(MaxKeys)) begin
                     st_in = ST_FULL;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_DUP_RDA;
                  end
               end
               default: begin
                  st_in = ST_IGNORED;
                  state_in = S_FINISH;
               end
            endcase
         end
         S_LOOP_RD: state_in = S_LOOP_CHK;
         S_LOOP_CHK: begin
            if (sts.dur_zero) begin
               j_in = '0;
               state_in = S_SRCH_RD;
            end else begin
               step_in  = '0;
               alpha_in = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            step_in = step_ff + 1'b1;
            if (alpha_ff && step_ff == StepW'(AlphaW - 1)) begin
               lane_in  = LANE_POS_X;
               state_in = S_MIX_MUL;
            end else if (!alpha_ff && step_ff == StepW'(DivW - 1)) begin
               state_in = S_MOD_DONE;
            end
         end
         S_MOD_DONE: begin
            j_in = '0;
            state_in = S_SRCH_RD;
         end
         S_SRCH_RD: begin
            if (j_ff == cnt_ff) srch_done = 1'b1;
            else state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (sts.time_gt) begin
               srch_done = 1'b1;
            end else begin
               j_in = jp1;
               state_in = S_SRCH_RD;
            end
         end
         S_SHUP_RD: begin
            if (j_ff == pos_ff) state_in = S_FIN_WR;
            else state_in = S_SHUP_WR;
         end
         S_SHUP_WR: begin
            j_in = jm1;
            state_in = S_SHUP_RD;
         end
         S_FIN_WR: begin
            cnt_in = cnt_ff + 1'b1;
            state_in = S_FINISH;
         end
         S_DEL_RD: begin
            if (jp1 < cnt_ff) begin
               state_in = S_DEL_WR;
            end else begin
               cnt_in = cntm1;
               state_in = S_FINISH;
            end
         end
         S_DEL_WR: begin
            j_in = jp1;
            state_in = S_DEL_RD;
         end
         S_SW_RDA: state_in = S_SW_RDB;
         S_SW_RDB: state_in = S_SW_WRA;
         S_SW_WRA: state_in = S_SW_WRB;
         S_SW_WRB: state_in = S_FINISH;
         S_DUP_RDA: state_in = S_DUP_RDB;
         S_DUP_RDB: state_in = S_DUP_T;
         S_DUP_T: begin
            pos_in = idx5 + 1'b1;
            j_in   = cnt_ff;
            state_in = S_SHUP_RD;
         end
         S_Q_RDA: state_in = S_Q_RDB;
         S_Q_RDB: state_in = S_Q_DIV;
         S_Q_DIV: begin
            step_in  = '0;
            alpha_in = 1'b1;
            state_in = S_DIV;
         end
         S_EMIT_RD: state_in = S_EMIT;
         S_EMIT: state_in = S_FINISH;
         S_MIX_MUL: state_in = S_MIX_ACC;
         S_MIX_ACC: begin
            if (lane_ff == LANE_ALPHA) begin
               state_in = S_FINISH;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = S_MIX_MUL;
            end
         end
         S_FINISH: begin
            if (!sts.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // branch once the search has found its key
      if (srch_done) begin
         if (sts.opcode == OP_INSERT) begin
            pos_in   = j_ff;
            j_in     = cnt_ff;
            state_in = S_SHUP_RD;
         end else if (j_ff == cnt_ff || j_ff == '0) begin
            pos_in   = (j_ff == '0) ? '0 : cntm1;
            state_in = S_EMIT_RD;
         end else begin
            pos_in   = jm1;
            state_in = S_Q_RDA;
         end
      end
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      cmd.wr_sel = WR_COPY;
      cmd.c_sel  = C_REQ;
      cmd.lane   = lane_ff;
      cmd.status = st_ff;
      cmd.count  = cnt_ff;
      unique case (state_ff)
         S_IDLE: cmd.req_load = req_valid;
         S_DECODE: begin
            cmd.frame_clr = 1'b1;
            cmd.c_load    = 1'b1;
            cmd.c_sel     = C_REQ;
         end
         S_LOOP_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = cntm1[IdxW-1:0];
         end
         S_LOOP_CHK: begin
            if (sts.dur_zero) begin
               cmd.c_load = 1'b1;
               cmd.c_sel  = C_ZERO;
            end else begin
               cmd.div_mod_start = 1'b1;
            end
         end
         S_DIV: cmd.div_step = 1'b1;
         S_MOD_DONE: begin
            cmd.c_load = 1'b1;
            cmd.c_sel  = C_REM;
         end
         S_SRCH_RD: begin
            cmd.rd_en   = (j_ff != cnt_ff);
            cmd.rd_addr = j_ff[IdxW-1:0];
         end
         S_SRCH_CMP: ;
         S_SHUP_RD: begin
            cmd.rd_en   = (j_ff != pos_ff);
            cmd.rd_addr = jm1[IdxW-1:0];
         end
         S_SHUP_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = j_ff[IdxW-1:0];
            cmd.wr_sel  = WR_COPY;
         end
         S_FIN_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = pos_ff[IdxW-1:0];
            cmd.wr_sel  = (sts.opcode == OP_INSERT) ? WR_NEW : WR_DUP;
         end
         S_DEL_RD: begin
            cmd.rd_en   = (jp1 < cnt_ff);
            cmd.rd_addr = jp1[IdxW-1:0];
         end
         S_DEL_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = j_ff[IdxW-1:0];
            cmd.wr_sel  = WR_COPY;
         end
         S_SW_RDA, S_Q_RDA, S_EMIT_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = pos_ff[IdxW-1:0];
         end
         S_SW_RDB, S_Q_RDB: begin
            cmd.hold_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_addr   = posp1[IdxW-1:0];
         end
         S_SW_WRA: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = pos_ff[IdxW-1:0];
            cmd.wr_sel  = WR_SWAP_A;
         end
         S_SW_WRB: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = posp1[IdxW-1:0];
            cmd.wr_sel  = WR_SWAP_B;
         end
         S_DUP_RDA: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = sts.index;
         end
         S_DUP_RDB: begin
            cmd.hold_load = 1'b1;
            cmd.rd_en     = 1'b1;
            cmd.rd_addr   = sts.index + 1'b1;
         end
         S_DUP_T: begin
            cmd.nt_load  = 1'b1;
            cmd.dup_last = (idx5 + 1'b1 == cnt_ff);
         end
         S_Q_DIV: cmd.div_alpha_start = 1'b1;
         S_EMIT: cmd.emit = 1'b1;
         S_MIX_MUL: cmd.mul = 1'b1;
         S_MIX_ACC: cmd.acc = 1'b1;
         S_FINISH: cmd.rsp_load = !sts.rsp_busy;
         default: ;
      endcase
   end

endmodule

// File: design/kti_datapath.sv
module kti_datapath (
   input  logic             clock,
   input  logic             reset,
   input  kti_pkg::req_type req_data,
   input  kti_pkg::cmd_type cmd,
   output kti_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kti_pkg::rsp_type rsp_data
);
   import kti_pkg::*;

   entry_type          mem [MaxKeys];
   entry_type          rd_ff, hold_ff, wr_data;
   req_type            req_ff;
   logic [31:0]        c_ff, c_in;
   logic [31:0]        rem_ff, quo_ff, den_ff;
   logic [32:0]        trial;
   logic               ge;
   logic [31:0]        nt_ff;
   logic [32:0]        mid_sum, inc_sum;
   logic signed [32:0] a33, b33, diff;
   logic signed [16:0] alpha17;
   logic signed [49:0] prod_ff, rnd;
   logic signed [32:0] mixed;
   rsp_type            frame_ff, rsp_ff, rsp_in;
   logic               rsp_valid_ff;

   // request register
   always_ff @(posedge clock) begin
      if (cmd.req_load) req_ff <= req_data;
   end

   // choose the entry to write
   always_comb begin
      case (cmd.wr_sel)
         WR_COPY: wr_data = rd_ff;
         WR_NEW: begin
            wr_data.key_time = req_ff.time_req;
            wr_data.pos_x    = req_ff.pos_x;
            wr_data.pos_y    = req_ff.pos_y;
            wr_data.size_x   = req_ff.size_x;
            wr_data.size_y   = req_ff.size_y;
            wr_data.angle    = req_ff.angle;
            wr_data.color    = req_ff.color_in;
            wr_data.list     = req_ff.list_in;
         end
         WR_SWAP_A: begin
            wr_data = rd_ff;
            wr_data.key_time = hold_ff.key_time;
         end
         WR_SWAP_B: begin
            wr_data = hold_ff;
            wr_data.key_time = rd_ff.key_time;
         end
         WR_DUP: begin
            wr_data = hold_ff;
            wr_data.key_time = nt_ff;
         end
         default: wr_data = rd_ff;
      endcase
   end

   // key table
   always_ff @(posedge clock) begin
      if (cmd.wr_en) mem[cmd.wr_addr] <= wr_data;
      if (cmd.rd_en) rd_ff <= mem[cmd.rd_addr];
      if (cmd.hold_load) hold_ff <= rd_ff;
   end

   // query time register
   always_comb begin
      case (cmd.c_sel)
         C_REQ:  c_in = req_ff.time_req;
         C_ZERO: c_in = '0;
         C_REM:  c_in = rem_ff;
         default: c_in = req_ff.time_req;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.c_load) c_ff <= c_in;
   end

   // restoring divider, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[31]};
   assign ge    = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_mod_start) begin
         rem_ff <= '0;
         quo_ff <= req_ff.time_req;
         den_ff <= rd_ff.key_time;
      end else if (cmd.div_alpha_start) begin
         rem_ff <= c_ff - hold_ff.key_time;
         quo_ff <= '0;
         den_ff <= rd_ff.key_time - hold_ff.key_time;
      end else if (cmd.div_step) begin
         rem_ff <= ge ? 32'(trial - {1'b0, den_ff}) : trial[31:0];
         quo_ff <= {quo_ff[30:0], ge};
      end
   end

   // duplicate time: midpoint, or last plus a tenth with saturation
   assign mid_sum = {1'b0, hold_ff.key_time} + {1'b0, rd_ff.key_time};
   assign inc_sum = {1'b0, hold_ff.key_time} + {1'b0, DupStep};

   always_ff @(posedge clock) begin
      if (cmd.nt_load) begin
         if (cmd.dup_last) nt_ff <= inc_sum[32] ? '1 : inc_sum[31:0];
         else nt_ff <= mid_sum[32:1];
      end
   end

   // pick the two values of one blend lane
   always_comb begin
      case (cmd.lane)
         LANE_POS_X: begin
            a33 = 33'(hold_ff.pos_x);
            b33 = 33'(rd_ff.pos_x);
         end
         LANE_POS_Y: begin
            a33 = 33'(hold_ff.pos_y);
            b33 = 33'(rd_ff.pos_y);
         end
         LANE_SIZE_X: begin
            a33 = 33'(hold_ff.size_x);
            b33 = 33'(rd_ff.size_x);
         end
         LANE_SIZE_Y: begin
            a33 = 33'(hold_ff.size_y);
            b33 = 33'(rd_ff.size_y);
         end
         LANE_ANGLE: begin
            a33 = 33'(hold_ff.angle);
            b33 = 33'(rd_ff.angle);
         end
         LANE_RED: begin
            a33 = {25'd0, hold_ff.color[31:24]};
            b33 = {25'd0, rd_ff.color[31:24]};
         end
         LANE_GREEN: begin
            a33 = {25'd0, hold_ff.color[23:16]};
            b33 = {25'd0, rd_ff.color[23:16]};
         end
         LANE_BLUE: begin
            a33 = {25'd0, hold_ff.color[15:8]};
            b33 = {25'd0, rd_ff.color[15:8]};
         end
         default: begin
            a33 = {25'd0, hold_ff.color[7:0]};
            b33 = {25'd0, rd_ff.color[7:0]};
         end
      endcase
   end

   assign diff    = b33 - a33;
   assign alpha17 = $signed({1'b0, quo_ff[AlphaW-1:0]});
   assign rnd     = (prod_ff + 50'sd32768) >>> 16;
   assign mixed   = a33 + rnd[32:0];

   // blend product
   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= diff * alpha17;
   end

   // frame being built
   always_ff @(posedge clock) begin
      if (cmd.frame_clr) begin
         frame_ff <= '0;
      end else if (cmd.emit) begin
         frame_ff.out_pos_x  <= rd_ff.pos_x;
         frame_ff.out_pos_y  <= rd_ff.pos_y;
         frame_ff.out_size_x <= rd_ff.size_x;
         frame_ff.out_size_y <= rd_ff.size_y;
         frame_ff.out_angle  <= rd_ff.angle;
         frame_ff.out_color  <= rd_ff.color;
         frame_ff.out_list   <= rd_ff.list;
      end else if (cmd.acc) begin
         frame_ff.out_list <= hold_ff.list;
         case (cmd.lane)
            LANE_POS_X:  frame_ff.out_pos_x  <= mixed[31:0];
            LANE_POS_Y:  frame_ff.out_pos_y  <= mixed[31:0];
            LANE_SIZE_X: frame_ff.out_size_x <= mixed[31:0];
            LANE_SIZE_Y: frame_ff.out_size_y <= mixed[31:0];
            LANE_ANGLE:  frame_ff.out_angle  <= mixed[31:0];
            LANE_RED:    frame_ff.out_color[31:24] <= mixed[7:0];
            LANE_GREEN:  frame_ff.out_color[23:16] <= mixed[7:0];
            LANE_BLUE:   frame_ff.out_color[15:8]  <= mixed[7:0];
            default:     frame_ff.out_color[7:0]   <= mixed[7:0];
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // merge status and key count into the frame
   always_comb begin
      rsp_in = frame_ff;
      rsp_in.status = cmd.status;
      rsp_in.key_count_out = cmd.count;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign sts.opcode   = req_ff.opcode;
   assign sts.index    = req_ff.index;
   assign sts.time_gt  = (rd_ff.key_time > c_ff);
   assign sts.dur_zero = (rd_ff.key_time == '0);
   assign sts.rsp_busy = rsp_valid_ff & ~rsp_ready;

endmodule

// File: sim/kti_checker.sv
// Watches both channels of the keyframe table, keeps its own copy of the table
// and of loop mode, predicts each response and compares it field by field.
module kti_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  kti_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  kti_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic             csr_wdata,
   output int               errors,
   output int               pending,
   output int               queries
);
   import kti_pkg::*;

   entry_type   frames[MaxKeys];
   int unsigned frame_count;
   logic        loop_on;
   rsp_type     expected_rsps[$];

   initial begin
      errors  = 0;
      pending = 0;
      queries = 0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: response mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
   endtask

   // index of the first frame later than t, or frame_count
   function automatic int unsigned first_later(input logic [31:0] t);
      int unsigned i;
      for (i = 0; i < frame_count; i++) begin
         if (frames[i].key_time > t) break;
      end
      return i;
   endfunction

   function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                         input longint alpha);
      longint d;
      d = (longint'($signed(b)) - longint'($signed(a))) * alpha + 64'sd32768;
      return a + 32'(d >>> 16);
   endfunction

   function automatic logic [7:0] blend_byte(input logic [7:0] a, input logic [7:0] b,
                                             input longint alpha);
      longint v;
      v = longint'(a) + (((longint'(b) - longint'(a)) * alpha + 64'sd32768) >>> 16);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   function automatic rsp_type frame_fields(input entry_type e);
      rsp_type r;
      r = '0;
      r.out_pos_x  = e.pos_x;
      r.out_pos_y  = e.pos_y;
      r.out_size_x = e.size_x;
      r.out_size_y = e.size_y;
      r.out_angle  = e.angle;
      r.out_color  = e.color;
      r.out_list   = e.list;
      return r;
   endfunction

   function automatic rsp_type lookup_frame(input logic [31:0] t);
      rsp_type     r;
      logic [31:0] c, dur, t0, t1;
      int unsigned k;
      longint      alpha;
      entry_type   e0, e1;
      r = '0;
      if (frame_count == 0) begin
         r.status = ST_EMPTY;
         return r;
      end
      c = t;
      if (loop_on) begin
         dur = frames[frame_count-1].key_time;
         c = (dur == 0) ? 32'd0 : t % dur;
      end
      k = first_later(c);
      if (k >= frame_count) return frame_fields(frames[frame_count-1]);
      if (k == 0) return frame_fields(frames[0]);
      e0 = frames[k-1];
      e1 = frames[k];
      t0 = e0.key_time;
      t1 = e1.key_time;
      alpha = longint'((64'(c - t0) << 16) / 64'(t1 - t0));
      r.out_pos_x  = blend(e0.pos_x, e1.pos_x, alpha);
      r.out_pos_y  = blend(e0.pos_y, e1.pos_y, alpha);
      r.out_size_x = blend(e0.size_x, e1.size_x, alpha);
      r.out_size_y = blend(e0.size_y, e1.size_y, alpha);
      r.out_angle  = blend(e0.angle, e1.angle, alpha);
      for (int ch = 0; ch < 4; ch++)
         r.out_color[ch*8 +: 8] = blend_byte(e0.color[ch*8 +: 8], e1.color[ch*8 +: 8], alpha);
      r.out_list = e0.list;
      return r;
   endfunction

   // swap all contents of two frames but keep their times in place
   task automatic swap_frames(input int unsigned a, input int unsigned b);
      entry_type   tmp;
      logic [31:0] ta, tb;
      ta = frames[a].key_time;
      tb = frames[b].key_time;
      tmp = frames[a];
      frames[a] = frames[b];
      frames[b] = tmp;
      frames[a].key_time = ta;
      frames[b].key_time = tb;
   endtask

   // shift frames at and above pos up by one
   task automatic open_gap(input int unsigned pos);
      for (int unsigned j = frame_count; j > pos; j--)
         frames[j] = frames[j-1];
      frame_count++;
   endtask

   task automatic apply_request(input req_type q, output rsp_type r);
      int unsigned p, id;
      logic [32:0] sum;
      logic [31:0] nt;
      r = '0;
      id = q.index;
      case (q.opcode)
         OP_INSERT: begin
            if (frame_count >= MaxKeys) begin
               r.status = ST_FULL;
            end else begin
               p = first_later(q.time_req);
               open_gap(p);
               frames[p] = '{key_time: q.time_req, pos_x: q.pos_x, pos_y: q.pos_y,
                             size_x: q.size_x, size_y: q.size_y, angle: q.angle,
                             color: q.color_in, list: q.list_in};
            end
         end
         OP_QUERY: begin
            r = lookup_frame(q.time_req);
            queries++;
         end
         OP_DELETE: begin
            if (id >= frame_count) begin
               r.status = ST_IGNORED;
            end else begin
               for (int unsigned j = id; j + 1 < frame_count; j++)
                  frames[j] = frames[j+1];
               frame_count--;
            end
         end
         OP_MOVE_DN: begin
            if (id == 0 || id >= frame_count) r.status = ST_IGNORED;
            else swap_frames(id - 1, id);
         end
         OP_MOVE_UP: begin
            if (id + 1 >= frame_count) r.status = ST_IGNORED;
            else swap_frames(id, id + 1);
         end
         OP_DUP: begin
            if (id >= frame_count) begin
               r.status = ST_IGNORED;
            end else if (frame_count >= MaxKeys) begin
               r.status = ST_FULL;
            end else begin
               if (id == frame_count - 1) begin
                  sum = {1'b0, frames[id].key_time} + {1'b0, DupStep};
                  nt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               end else begin
                  sum = {1'b0, frames[id].key_time} + {1'b0, frames[id+1].key_time};
                  nt = sum[32:1];
               end
               open_gap(id + 1);
               frames[id+1] = frames[id];
               frames[id+1].key_time = nt;
            end
         end
         default: r.status = ST_IGNORED;
      endcase
      r.key_count_out = 5'(frame_count);
   endtask

   task automatic compare(input rsp_type got, input rsp_type want);
      if (got.out_pos_x !== want.out_pos_x) report("pos_x", got.out_pos_x, want.out_pos_x);
      if (got.out_pos_y !== want.out_pos_y) report("pos_y", got.out_pos_y, want.out_pos_y);
      if (got.out_size_x !== want.out_size_x)
         report("size_x", got.out_size_x, want.out_size_x);
      if (got.out_size_y !== want.out_size_y)
         report("size_y", got.out_size_y, want.out_size_y);
      if (got.out_angle !== want.out_angle) report("angle", got.out_angle, want.out_angle);
      if (got.out_color !== want.out_color) report("color", got.out_color, want.out_color);
      if (got.out_list !== want.out_list) report("list", got.out_list, want.out_list);
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.key_count_out !== want.key_count_out)
         report("key_count", got.key_count_out, want.key_count_out);
   endtask

   // check responses first, then record the request taken at the same edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         frame_count = 0;
         loop_on = 1'b0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected response", rsp_data.status, '0);
            end else begin
               want = expected_rsps.pop_front();
               compare(rsp_data, want);
            end
         end
         if (req_valid && req_ready) begin
            apply_request(req_data, want);
            expected_rsps.push_back(want);
         end
         if (csr_we) loop_on = csr_wdata;
      end
      pending = expected_rsps.size();
   end

endmodule

// File: sim/tb_keyframe_table_interpolator_top.sv
module tb_keyframe_table_interpolator_top;
   import kti_pkg::*;

   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;
   localparam int CycleLimit = 1000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic    csr_wdata;

   int errors, pending, queries;
   int cycles;
   int sent;
   int burst_left;
   bit fill_bias;

   keyframe_table_interpolator_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   kti_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending),
      .queries   (queries)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // stop a hung run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d responses still owed", cycles, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver: stall in segments of varying density, with one long hold-off
   initial begin
      int  mode, seg_len, stall_pct;
      bit  held;
      held = 0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && cycles >= 4000) begin
            rsp_ready <= 1'b0;
            repeat (1500) @(posedge clock);
            held = 1;
         end
         mode = $urandom_range(0, 3);
         seg_len = $urandom_range(50, 400);
         stall_pct = (mode == 0) ? 0 : (mode == 1) ? 20 : (mode == 2) ? 50 : 85;
         repeat (seg_len) begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
            @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_time();
      case ($urandom_range(0, 19))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'hFFFF_0000 + $urandom_range(0, 'hFFFF);
         3, 4, 5: return $urandom;
         default: return $urandom_range(0, 'h80000);
      endcase
   endfunction

   function automatic req_type make_req(input logic [2:0] op, input logic [31:0] t,
                                        input logic [3:0] idx);
      req_type r;
      r.opcode   = op;
      r.time_req = t;
      r.index    = idx;
      r.pos_x    = pick_word();
      r.pos_y    = pick_word();
      r.size_x   = pick_word();
      r.size_y   = pick_word();
      r.angle    = pick_word();
      r.color_in = pick_word();
      r.list_in  = 16'(pick_word());
      return r;
   endfunction

   // offer one request; bursts of random length with random gaps between them
   task automatic send(input req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_op(input logic [2:0] op, input logic [31:0] t, input logic [3:0] idx);
      send(make_req(op, t, idx));
   endtask

   // drop valid, drain all owed responses, then write loop mode
   task automatic set_loop(input logic mode);
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_requests(input int count);
      logic [2:0] op;
      int         pick;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) fill_bias = $urandom_range(0, 1);
         pick = $urandom_range(0, 99);
         if (fill_bias)
            op = (pick < 40) ? OP_INSERT : (pick < 65) ? OP_QUERY : (pick < 70) ? OP_DELETE :
                 (pick < 78) ? OP_MOVE_DN : (pick < 86) ? OP_MOVE_UP : (pick < 97) ? OP_DUP :
                 (pick < 98) ? OP_SPARE_6 : OP_SPARE_7;
         else
            op = (pick < 10) ? OP_INSERT : (pick < 35) ? OP_QUERY : (pick < 75) ? OP_DELETE :
                 (pick < 83) ? OP_MOVE_DN : (pick < 91) ? OP_MOVE_UP : (pick < 97) ? OP_DUP :
                 (pick < 98) ? OP_SPARE_6 : OP_SPARE_7;
         send_op(op, pick_time(), 4'($urandom_range(0, 15)));
      end
   endtask

   initial begin
      req_type r;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_we     = 1'b0;
      csr_wdata  = 1'b0;
      sent       = 0;
      burst_left = 0;
      fill_bias  = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table, ignored indexes and spare opcodes
      set_loop(1'b0);
      send_op(OP_QUERY, 32'h0, 4'd0);
      send_op(OP_DELETE, 32'h0, 4'd0);
      send_op(OP_MOVE_DN, 32'h0, 4'd0);
      send_op(OP_MOVE_UP, 32'h0, 4'd0);
      send_op(OP_DUP, 32'h0, 4'd0);
      send_op(OP_SPARE_6, 32'h0, 4'd0);
      send_op(OP_SPARE_7, 32'h0, 4'd15);
      // extreme payloads, equal times, ends and the middle of a span
      r = make_req(OP_INSERT, 32'h1_0000, 4'd0);
      r.pos_x = 32'h7FFF_FFFF; r.pos_y = 32'h8000_0000; r.size_x = 32'h7FFF_FFFF;
      r.size_y = 32'h8000_0000; r.angle = 32'h7FFF_FFFF; r.color_in = 32'hFF00_FF00;
      r.list_in = 16'hFFFF;
      send(r);
      r = make_req(OP_INSERT, 32'h3_0000, 4'd0);
      r.pos_x = 32'h8000_0000; r.pos_y = 32'h7FFF_FFFF; r.size_x = 32'h8000_0000;
      r.size_y = 32'h7FFF_FFFF; r.angle = 32'h8000_0000; r.color_in = 32'h00FF_00FF;
      r.list_in = 16'h0000;
      send(r);
      send_op(OP_INSERT, 32'h1_0000, 4'd0);
      send_op(OP_QUERY, 32'h0, 4'd0);
      send_op(OP_QUERY, 32'h2_0000, 4'd0);
      send_op(OP_QUERY, 32'h1_0000, 4'd0);
      send_op(OP_QUERY, 32'hFFFF_FFFF, 4'd0);
      send_op(OP_MOVE_DN, 32'h0, 4'd1);
      send_op(OP_MOVE_UP, 32'h0, 4'd0);
      send_op(OP_MOVE_UP, 32'h0, 4'd2);
      send_op(OP_MOVE_DN, 32'h0, 4'd3);
      send_op(OP_DUP, 32'h0, 4'd2);
      send_op(OP_DUP, 32'h0, 4'd0);
      send_op(OP_DELETE, 32'h0, 4'd15);
      send_op(OP_DELETE, 32'h0, 4'd4);
      send_op(OP_INSERT, 32'hFFFF_FFFF, 4'd0);
      send_op(OP_DUP, 32'h0, 4'd4);
      random_requests(300);

      // loop mode, starting with a zero-length animation
      set_loop(1'b1);
      repeat (17) send_op(OP_DELETE, 32'h0, 4'd0);
      send_op(OP_INSERT, 32'h0, 4'd0);
      send_op(OP_INSERT, 32'h0, 4'd0);
      send_op(OP_QUERY, $urandom, 4'd0);
      send_op(OP_QUERY, 32'h0, 4'd0);
      random_requests(350);

      set_loop(1'b0);
      random_requests(350);
      set_loop(1'b1);
      random_requests(350);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (200) @(posedge clock);

      $display("Sent %0d requests, %0d of them queries, in phases with loop mode off and on.",
               sent, queries);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", errors);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
